@@ sv/tolerance_peak_binner_assert.svh @@
// Assertion macros for the tolerance peak binner.
// Included by the top level; relies on nothing else.
`ifndef TOLERANCE_PEAK_BINNER_ASSERT_SVH
`define TOLERANCE_PEAK_BINNER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define TPB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpb check failed");
// Next-cycle implication, disabled while reset is high.
`define TPB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpb check failed");
`else
`define TPB_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TPB_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ sv/tpb_pkg.sv @@
// Shared constants, codes and types of the tolerance peak binner.
// Used by the interfaces and by all modules but tpb_ram; depends on nothing.
package tpb_pkg;

   localparam int MAX_BINS = 128;
   localparam int PIXELS   = 256;
   localparam int BIN_W    = $clog2(MAX_BINS);
   localparam int PIX_W    = $clog2(PIXELS);
   localparam int CELL_AW  = BIN_W + PIX_W;
   localparam int CELLS    = MAX_BINS * PIXELS;
   localparam int USED_W   = $clog2(MAX_BINS + 1);

   localparam int MASS_W = 32;
   localparam int INT_W  = 32;
   localparam int SNR_W  = 16;
   localparam int AREA_W = 32;
   localparam int CNT_W  = 16;
   localparam int TOL_W  = 24;
   localparam int SEL_W  = 7;
   localparam int IDX_W  = 7;
   localparam int BU_W   = 8;
   localparam int STAT_W = 2;
   localparam int CELL_W = INT_W + SNR_W + AREA_W;

   // d * 1e6 * 256 folded into one constant factor.
   localparam int PPM_W  = 28;
   localparam logic [PPM_W-1:0] PPM_FACTOR = PPM_W'(256000000);
   localparam int LHS_W  = MASS_W + PPM_W;
   localparam int RHS_W  = TOL_W + MASS_W;

   localparam int Q_DEPTH = 2;

   localparam logic CMD_BIN  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [1:0] KIND_BIN  = 2'd0;
   localparam logic [1:0] KIND_READ = 2'd1;
   localparam logic [1:0] KIND_DROP = 2'd2;

   localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_NO_EXTRAS = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_UNUSED    = 2'd3;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic REG_TOLERANCE = 1'b0;
   localparam logic REG_PPM_MODE  = 1'b1;
   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1280);

   typedef struct packed {
      logic [1:0]        kind;
      logic [MASS_W-1:0] mass;
      logic [INT_W-1:0]  intensity;
      logic [SNR_W-1:0]  snr;
      logic [AREA_W-1:0] area;
      logic [MASS_W-1:0] peak_width;
      logic [PIX_W-1:0]  pix;
      logic              extras;
      logic [SEL_W-1:0]  sel;
   } tpb_entry_type;

   typedef struct packed {
      logic [IDX_W-1:0]  bin_index;
      logic              new_bin;
      logic [MASS_W-1:0] bin_center;
      logic [CNT_W-1:0]  bin_count;
      logic [INT_W-1:0]  cell_intensity;
      logic [SNR_W-1:0]  cell_snr;
      logic [AREA_W-1:0] cell_area;
      logic [BU_W-1:0]   bins_used;
      logic [STAT_W-1:0] status;
   } tpb_result_type;

   typedef struct packed {
      logic pop;
      logic init_done;
   } tpb_ctl_type;

endpackage

@@ sv/tpb_req_if.sv @@
// Request channel of the tolerance peak binner: valid, ready and one peak or read command.
// Depends on tpb_pkg.
interface tpb_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [tpb_pkg::MASS_W-1:0]    mass;
   logic [tpb_pkg::INT_W-1:0]     intensity;
   logic [tpb_pkg::SNR_W-1:0]     snr;
   logic [tpb_pkg::AREA_W-1:0]    area;
   logic [tpb_pkg::MASS_W-1:0]    peak_width;
   logic [7:0]                    pixel;
   logic                          has_extras;
   logic [tpb_pkg::SEL_W-1:0]     bin_select;

   modport source (output valid, command, mass, intensity, snr, area, peak_width, pixel,
                   has_extras, bin_select, input ready);
   modport sink (input valid, command, mass, intensity, snr, area, peak_width, pixel,
                 has_extras, bin_select, output ready);
endinterface

@@ sv/tpb_rsp_if.sv @@
// Result channel of the tolerance peak binner: valid, ready and one result.
// Depends on tpb_pkg.
interface tpb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tpb_pkg::IDX_W-1:0]     bin_index;
   logic                          new_bin;
   logic [tpb_pkg::MASS_W-1:0]    bin_center;
   logic [tpb_pkg::CNT_W-1:0]     bin_count;
   logic [tpb_pkg::INT_W-1:0]     cell_intensity;
   logic [tpb_pkg::SNR_W-1:0]     cell_snr;
   logic [tpb_pkg::AREA_W-1:0]    cell_area;
   logic [tpb_pkg::BU_W-1:0]      bins_used;
   logic [tpb_pkg::STAT_W-1:0]    status;

   modport source (output valid, bin_index, new_bin, bin_center, bin_count, cell_intensity,
                   cell_snr, cell_area, bins_used, status, input ready);
   modport sink (input valid, bin_index, new_bin, bin_center, bin_count, cell_intensity,
                 cell_snr, cell_area, bins_used, status, output ready);
endinterface

@@ sv/tpb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module tpb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/tpb_front.sv @@
// Front end of the tolerance peak binner: takes requests, classifies them and queues them.
// Depends on tpb_pkg and tpb_req_if.
module tpb_front (
   input  logic                   clock,
   input  logic                   reset,
   tpb_req_if.sink                req_chan,
   input  logic                   ppm_mode,
   input  tpb_pkg::tpb_ctl_type   ctl,
   output logic                   ent_vld,
   output tpb_pkg::tpb_entry_type ent
);

   localparam int QP_W = $clog2(tpb_pkg::Q_DEPTH);
   localparam int QC_W = $clog2(tpb_pkg::Q_DEPTH + 1);

   tpb_pkg::tpb_entry_type q_ff [tpb_pkg::Q_DEPTH];
   tpb_pkg::tpb_entry_type new_ent;
   logic [QP_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QC_W-1:0] cnt_ff, cnt_in;
   logic            push, pop;

   assign req_chan.ready = ctl.init_done && (cnt_ff != QC_W'(tpb_pkg::Q_DEPTH));
   assign push = req_chan.valid && req_chan.ready;
   assign pop  = ctl.pop && ent_vld;

   // A bin command in absolute mode without snr and area is settled right here.
   always_comb begin
      new_ent.mass       = req_chan.mass;
      new_ent.intensity  = req_chan.intensity;
      new_ent.snr        = req_chan.snr;
      new_ent.area       = req_chan.area;
      new_ent.peak_width = req_chan.peak_width;
      new_ent.pix        = req_chan.pixel[tpb_pkg::PIX_W-1:0];
      new_ent.extras     = req_chan.has_extras;
      new_ent.sel        = req_chan.bin_select;
      if (req_chan.command == tpb_pkg::CMD_READ) begin
         new_ent.kind = tpb_pkg::KIND_READ;
      end else if (!ppm_mode && !req_chan.has_extras) begin
         new_ent.kind = tpb_pkg::KIND_DROP;
      end else begin
         new_ent.kind = tpb_pkg::KIND_BIN;
      end
   end

   always_comb begin
      wp_in  = push ? QP_W'(wp_ff + 1'b1) : wp_ff;
      rp_in  = pop ? QP_W'(rp_ff + 1'b1) : rp_ff;
      cnt_in = QC_W'(cnt_ff + QC_W'(push) - QC_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= new_ent;
      end
   end

   assign ent_vld = (cnt_ff != '0);
   assign ent     = q_ff[rp_ff];

endmodule

@@ sv/tpb_back.sv @@
// Back end of the tolerance peak binner: center scan, join test, table updates and result.
// Depends on tpb_pkg, tpb_rsp_if and tpb_ram.
module tpb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ent_vld,
   input  tpb_pkg::tpb_entry_type        ent,
   input  logic [tpb_pkg::TOL_W-1:0]     tolerance,
   input  logic                          ppm_mode,
   output tpb_pkg::tpb_ctl_type          ctl,
   tpb_rsp_if.source                     rsp_chan
);

   localparam logic [2:0] ST_CLR  = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_DEC  = 3'd4;
   localparam logic [2:0] ST_RDW  = 3'd5;
   localparam logic [2:0] ST_EMIT = 3'd6;

   localparam int BW = tpb_pkg::BIN_W;
   localparam int UW = tpb_pkg::USED_W;
   localparam int MW = tpb_pkg::MASS_W;
   localparam int CW = tpb_pkg::CNT_W;

   logic [2:0]                   st_ff, st_in;
   logic [tpb_pkg::CELL_AW-1:0]  clr_ff, clr_in;
   tpb_pkg::tpb_entry_type       cur_ff, cur_in;
   logic [UW-1:0]                used_ff, used_in, scan_ff, scan_in;
   logic                         pend_ff, pend_in, found_ff, found_in, new_ff, new_in;
   logic [BW-1:0]                pidx_ff, pidx_in, best_ff, best_in, bin_ff, bin_in;
   logic [MW-1:0]                bestc_ff, bestc_in, bestd_ff, bestd_in;
   logic [tpb_pkg::LHS_W-1:0]    lhs_ff, lhs_in;
   logic [tpb_pkg::RHS_W-1:0]    rhs_ff, rhs_in;
   tpb_pkg::tpb_result_type      stage_ff, stage_in, out_ff, out_in;
   logic                         ovld_ff, ovld_in;

   logic                         c_we, n_we, x_we;
   logic [BW-1:0]                c_raddr, n_raddr;
   logic [MW-1:0]                c_wdata, c_rdata;
   logic [CW-1:0]                n_wdata, n_rdata;
   logic [tpb_pkg::CELL_AW-1:0]  x_waddr, x_raddr;
   logic [tpb_pkg::CELL_W-1:0]   x_wdata, x_rdata;

   logic [MW-1:0]                gap, mul_src;
   logic [MW:0]                  csum;
   logic [tpb_pkg::INT_W-1:0]    x_int, m_int;
   logic [tpb_pkg::SNR_W-1:0]    x_snr, m_snr;
   logic [tpb_pkg::AREA_W-1:0]   x_area, m_area;
   logic [CW-1:0]                m_cnt;
   logic [MW-1:0]                m_center;
   logic                         joins, slot_free;

   tpb_ram #(.WIDTH(MW), .DEPTH(tpb_pkg::MAX_BINS)) u_center_ram (
      .clock(clock), .we(c_we), .waddr(bin_ff), .wdata(c_wdata),
      .raddr(c_raddr), .rdata(c_rdata));

   tpb_ram #(.WIDTH(CW), .DEPTH(tpb_pkg::MAX_BINS)) u_count_ram (
      .clock(clock), .we(n_we), .waddr(bin_ff), .wdata(n_wdata),
      .raddr(n_raddr), .rdata(n_rdata));

   tpb_ram #(.WIDTH(tpb_pkg::CELL_W), .DEPTH(tpb_pkg::CELLS)) u_cell_ram (
      .clock(clock), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
      .raddr(x_raddr), .rdata(x_rdata));

   assign {x_int, x_snr, x_area} = x_rdata;
   assign slot_free = !ovld_ff || rsp_chan.ready;

   always_comb begin
      st_in    = st_ff;
      clr_in   = clr_ff;
      cur_in   = cur_ff;
      used_in  = used_ff;
      scan_in  = scan_ff;
      pend_in  = pend_ff;
      found_in = found_ff;
      new_in   = new_ff;
      pidx_in  = pidx_ff;
      best_in  = best_ff;
      bin_in   = bin_ff;
      bestc_in = bestc_ff;
      bestd_in = bestd_ff;
      lhs_in   = lhs_ff;
      rhs_in   = rhs_ff;
      stage_in = stage_ff;
      out_in   = out_ff;
      ovld_in  = ovld_ff && !rsp_chan.ready;
      ctl.pop  = 1'b0;
      ctl.init_done = (st_ff != ST_CLR);
      c_we     = 1'b0;
      n_we     = 1'b0;
      x_we     = 1'b0;
      c_raddr  = scan_ff[BW-1:0];
      n_raddr  = bin_ff;
      x_raddr  = {bin_ff, cur_ff.pix};
      x_waddr  = {bin_ff, cur_ff.pix};
      c_wdata  = cur_ff.mass;
      n_wdata  = CW'(1);
      x_wdata  = '0;
      gap      = (cur_ff.mass >= c_rdata) ? cur_ff.mass - c_rdata : c_rdata - cur_ff.mass;
      mul_src  = ppm_mode ? cur_ff.mass : cur_ff.peak_width;
      joins    = found_ff && (lhs_ff < tpb_pkg::LHS_W'(rhs_ff));
      csum     = {1'b0, bestc_ff} + {1'b0, cur_ff.mass};
      m_center = new_ff ? cur_ff.mass : csum[MW:1];
      m_cnt    = new_ff ? CW'(1) : ((n_rdata == '1) ? n_rdata : CW'(n_rdata + 1'b1));
      m_int    = (cur_ff.intensity > x_int) ? cur_ff.intensity : x_int;
      m_snr    = (cur_ff.extras && cur_ff.snr > x_snr) ? cur_ff.snr : x_snr;
      m_area   = (cur_ff.extras && cur_ff.area > x_area) ? cur_ff.area : x_area;

      case (st_ff)
         ST_CLR: begin
            x_we    = 1'b1;
            x_waddr = clr_ff;
            clr_in  = tpb_pkg::CELL_AW'(clr_ff + 1'b1);
            if (clr_ff == tpb_pkg::CELL_AW'(tpb_pkg::CELLS - 1)) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            c_raddr = ent.sel[BW-1:0];
            n_raddr = ent.sel[BW-1:0];
            x_raddr = {ent.sel[BW-1:0], ent.pix};
            if (ent_vld) begin
               ctl.pop  = 1'b1;
               cur_in   = ent;
               stage_in = '0;
               stage_in.bins_used = tpb_pkg::BU_W'(used_ff);
               case (ent.kind)
                  tpb_pkg::KIND_READ: begin
                     stage_in.bin_index = ent.sel;
                     if (UW'(ent.sel) >= used_ff) begin
                        stage_in.status = tpb_pkg::STATUS_UNUSED;
                        st_in = ST_EMIT;
                     end else begin
                        bin_in = ent.sel[BW-1:0];
                        st_in  = ST_RDW;
                     end
                  end
                  tpb_pkg::KIND_DROP: begin
                     stage_in.status = tpb_pkg::STATUS_NO_EXTRAS;
                     st_in = ST_EMIT;
                  end
                  default: begin
                     scan_in  = '0;
                     pend_in  = 1'b0;
                     found_in = 1'b0;
                     st_in    = ST_SCAN;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // One center read issued per cycle; its distance is compared in the cycle after its read.
            if (pend_ff && (!found_ff || gap < bestd_ff)) begin
               bestd_in = gap;
               bestc_in = c_rdata;
               best_in  = pidx_ff;
               found_in = 1'b1;
            end
            if (scan_ff < used_ff) begin
               pend_in = 1'b1;
               pidx_in = scan_ff[BW-1:0];
               scan_in = UW'(scan_ff + 1'b1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  st_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            lhs_in = ppm_mode ? bestd_ff * tpb_pkg::PPM_FACTOR
                              : tpb_pkg::LHS_W'({bestd_ff, 8'b0});
            rhs_in = tolerance * mul_src;
            st_in  = ST_DEC;
         end
         ST_DEC: begin
            stage_in = '0;
            stage_in.bins_used = tpb_pkg::BU_W'(used_ff);
            if (joins) begin
               bin_in  = best_ff;
               new_in  = 1'b0;
               n_raddr = best_ff;
               x_raddr = {best_ff, cur_ff.pix};
               st_in   = ST_RDW;
            end else if (used_ff >= UW'(tpb_pkg::MAX_BINS)) begin
               stage_in.status = tpb_pkg::STATUS_FULL;
               st_in = ST_EMIT;
            end else begin
               bin_in  = used_ff[BW-1:0];
               new_in  = 1'b1;
               n_raddr = used_ff[BW-1:0];
               x_raddr = {used_ff[BW-1:0], cur_ff.pix};
               st_in   = ST_RDW;
            end
         end
         ST_RDW: begin
            stage_in.bin_index = tpb_pkg::IDX_W'(bin_ff);
            stage_in.status    = tpb_pkg::STATUS_OK;
            if (cur_ff.kind == tpb_pkg::KIND_READ) begin
               stage_in.new_bin        = 1'b0;
               stage_in.bin_center     = c_rdata;
               stage_in.bin_count      = n_rdata;
               stage_in.cell_intensity = x_int;
               stage_in.cell_snr       = x_snr;
               stage_in.cell_area      = x_area;
               stage_in.bins_used      = tpb_pkg::BU_W'(used_ff);
            end else begin
               c_we    = 1'b1;
               n_we    = 1'b1;
               x_we    = 1'b1;
               c_wdata = m_center;
               n_wdata = m_cnt;
               x_wdata = {m_int, m_snr, m_area};
               used_in = UW'(used_ff + UW'(new_ff));
               stage_in.new_bin        = new_ff;
               stage_in.bin_center     = m_center;
               stage_in.bin_count      = m_cnt;
               stage_in.cell_intensity = m_int;
               stage_in.cell_snr       = m_snr;
               stage_in.cell_area      = m_area;
               stage_in.bins_used      = tpb_pkg::BU_W'(used_in);
            end
            st_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_in  = stage_ff;
               ovld_in = 1'b1;
               st_in   = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_CLR;
         clr_ff  <= '0;
         used_ff <= '0;
         ovld_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         clr_ff  <= clr_in;
         used_ff <= used_in;
         ovld_ff <= ovld_in;
         pend_ff <= pend_in;
      end
      cur_ff   <= cur_in;
      scan_ff  <= scan_in;
      found_ff <= found_in;
      new_ff   <= new_in;
      pidx_ff  <= pidx_in;
      best_ff  <= best_in;
      bin_ff   <= bin_in;
      bestc_ff <= bestc_in;
      bestd_ff <= bestd_in;
      lhs_ff   <= lhs_in;
      rhs_ff   <= rhs_in;
      stage_ff <= stage_in;
      out_ff   <= out_in;
   end

   assign rsp_chan.valid          = ovld_ff;
   assign rsp_chan.bin_index      = out_ff.bin_index;
   assign rsp_chan.new_bin        = out_ff.new_bin;
   assign rsp_chan.bin_center     = out_ff.bin_center;
   assign rsp_chan.bin_count      = out_ff.bin_count;
   assign rsp_chan.cell_intensity = out_ff.cell_intensity;
   assign rsp_chan.cell_snr       = out_ff.cell_snr;
   assign rsp_chan.cell_area      = out_ff.cell_area;
   assign rsp_chan.bins_used      = out_ff.bins_used;
   assign rsp_chan.status         = out_ff.status;

endmodule

@@ sv/tolerance_peak_binner.sv @@
// Top level of the tolerance peak binner: register port, front end and back end.
// Depends on tpb_pkg, tpb_req_if, tpb_rsp_if, tpb_front, tpb_back and the assertion header.
//
// The binner groups mass peaks into bins by online leader clustering. After reset the block
// first clears its cell store, one (bin, pixel) cell per cycle; req_chan.ready stays low
// until the store is clear, while register writes are taken as usual. A bin command takes
// the entry from the queue, then scans the stored centers, which are read one per cycle
// through the single read port of the center memory, each distance being compared the cycle
// after its read; it then forms the two tolerance products, makes the join decision, reads
// and updates the count and cell, and hands the result to the output register once that is
// free. A read command reads the bin and hands its result on the same way; a read of an
// unused bin and a peak dropped for missing extras go straight to the output register. A
// two-entry queue sits between the front end, which accepts and classifies requests, and the
// back end, so that a new transfer can be accepted while the back end is busy or while a
// finished result waits in the output register. The tolerance test uses exact integer
// products, so no division is ever done. Registers are to be written by the user only while
// the block is idle; the block itself does not enforce this. tolerance sits at byte address
// 0 and ppm_mode at byte address 4.
`include "tolerance_peak_binner_assert.svh"

module tolerance_peak_binner (
   input  logic                          clock,
   input  logic                          reset,
   tpb_req_if.sink                       req_chan,
   tpb_rsp_if.source                     rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tpb_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [tpb_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [tpb_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);

   localparam logic [tpb_pkg::BU_W-1:0] FULL_USED = tpb_pkg::BU_W'(tpb_pkg::MAX_BINS);

   logic [tpb_pkg::TOL_W-1:0] tol_ff, tol_in;
   logic                      ppm_ff, ppm_in;
   logic                      csr_wr;
   logic                      reg_sel;
   logic                      ent_vld;
   tpb_pkg::tpb_entry_type    ent;
   tpb_pkg::tpb_ctl_type      ctl;
   logic                      req_xfer;
   logic                      rsp_full;
   logic                      rsp_new;

   // The register index is the word address; the byte offset within a word is ignored.
   assign reg_sel    = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      tol_in = tol_ff;
      ppm_in = ppm_ff;
      if (csr_wr) begin
         case (reg_sel)
            tpb_pkg::REG_TOLERANCE: tol_in = csr_pwdata[tpb_pkg::TOL_W-1:0];
            tpb_pkg::REG_PPM_MODE:  ppm_in = csr_pwdata[0];
            default: begin
               tol_in = tol_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         tpb_pkg::REG_TOLERANCE: csr_prdata = tpb_pkg::CSR_DW'(tol_ff);
         tpb_pkg::REG_PPM_MODE:  csr_prdata = tpb_pkg::CSR_DW'(ppm_ff);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= tpb_pkg::TOL_RESET;
         ppm_ff <= 1'b1;
      end else begin
         tol_ff <= tol_in;
         ppm_ff <= ppm_in;
      end
   end

   // The front end classifies each transfer and queues it for the back end.
   tpb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .ppm_mode (ppm_ff),
      .ctl      (ctl),
      .ent_vld  (ent_vld),
      .ent      (ent)
   );

   // The back end owns the center, count and cell memories and the output register.
   tpb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ent_vld   (ent_vld),
      .ent       (ent),
      .tolerance (tol_ff),
      .ppm_mode  (ppm_ff),
      .ctl       (ctl),
      .rsp_chan  (rsp_chan)
   );

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_full = rsp_chan.valid && (rsp_chan.status == tpb_pkg::STATUS_FULL);
   assign rsp_new  = rsp_chan.valid && rsp_chan.new_bin;

   // No request may enter before the cell store has been cleared.
   `TPB_ASSERT_IMP(a_no_accept_in_clear, clock, reset, req_xfer, ctl.init_done)
   // An accepted request is waiting in the queue on the next cycle.
   `TPB_ASSERT_NXT(a_accept_queued, clock, reset, req_xfer, ent_vld)
   // A peak is only dropped for a full table when every bin is in use.
   `TPB_ASSERT_IMP(a_full_means_full, clock, reset, rsp_full, rsp_chan.bins_used == FULL_USED)
   // A freshly opened bin holds exactly one peak.
   `TPB_ASSERT_IMP(a_new_bin_count, clock, reset, rsp_new, rsp_chan.bin_count == tpb_pkg::CNT_W'(1))

endmodule
